// ----- hdl/ascii_integer_parser_defines.svh -----
// Assertion macros for the files that check their own logic; ascii_integer_parser.sv uses them.
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AIP_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("aip assertion failed: same-cycle check");

// Checks that the consequent holds in the cycle after the antecedent.
`define AIP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("aip assertion failed: next-cycle check");

`endif

// ----- hdl/aip_pkg.sv -----
package aip_pkg;

    // Longest string index that is counted before the index saturates.
    localparam int unsigned MAX_CHARS = 65535;
    localparam logic [15:0] IDX_LIMIT =
        (MAX_CHARS < 65535) ? 16'(MAX_CHARS) : 16'hFFFF;

    // Character codes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;

    // Radix codes.
    localparam logic [5:0] BASE_DETECT = 6'd0;
    localparam logic [5:0] BASE_BAD    = 6'd1;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] BASE_HEX    = 6'd16;
    localparam logic [5:0] BASE_MAX    = 6'd36;

    // Digit worth of a byte that is not alphanumeric.
    localparam logic [6:0] NOT_DIGIT = 7'd99;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RADIX = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PREFIX,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS
    } phase_t;

    // How the byte in hand ends the parse, if it does.
    typedef enum logic [1:0] {
        STOP_NONE,
        STOP_BAD_RADIX,
        STOP_AT_X,
        STOP_AT_BYTE
    } stop_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [15:0]        end_index;
        logic               status;
    } result_t;

    // Worth of an alphanumeric byte (0..35), or NOT_DIGIT.
    function automatic logic [6:0] digit_worth(input logic [7:0] c);
        logic [6:0] w;
        begin
            w = NOT_DIGIT;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                w = 7'(c - CH_ZERO);
            end
            else if (c >= CH_LOW_A && c <= CH_LOW_Z)
            begin
                w = 7'(c - CH_LOW_A) + 7'd10;
            end
            else if (c >= CH_UP_A && c <= CH_UP_Z)
            begin
                w = 7'(c - CH_UP_A) + 7'd10;
            end
            return w;
        end
    endfunction

endpackage

// ----- hdl/aip_channels.sv -----
// Byte channel into the parser.
interface aip_in_if;
    import aip_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, output ch, output first, input ready);
    modport sink (input valid, input ch, input first, output ready);
endinterface

// Result channel out of the parser.
interface aip_out_if;
    import aip_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [15:0]        end_index;
    logic               status;

    modport source (output valid, output value, output end_index, output status,
                    input ready);
    modport sink (input valid, input value, input end_index, input status,
                  output ready);
endinterface

// ----- hdl/aip_in_stage.sv -----
module aip_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  aip_pkg::in_item_t in_item,
    output logic              in_ready,
    input  logic              take,
    output logic              item_valid,
    output aip_pkg::in_item_t item
);
    import aip_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register can refill in the same cycle that its item is taken.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ----- hdl/aip_parse.sv -----
module aip_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  aip_pkg::in_item_t item,
    input  logic [5:0]        radix,
    input  logic              out_free,
    output logic              take,
    output logic              emit,
    output aip_pkg::result_t  result
);
    import aip_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        neg_reg;
    logic        neg_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [5:0]  base_reg;
    logic [5:0]  base_next;
    stop_t       stop;
    logic [6:0]  worth;
    logic [15:0] x_index;

    assign take  = item_valid && out_free;
    assign worth = digit_worth(item.ch);

    // Next state: walks the phases that the byte in hand passes through.
    always_comb
    begin
        logic done;
        done       = 1'b0;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        base_next  = base_reg;
        stop       = STOP_NONE;

        if (item.first)
        begin
            neg_next  = 1'b0;
            acc_next  = 64'd0;
            pos_next  = 16'd0;
            base_next = radix;
            if (radix == BASE_BAD || radix > BASE_MAX)
            begin
                stop       = STOP_BAD_RADIX;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else
            begin
                phase_next = PH_LEAD;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            done = 1'b1;
        end
        else if (pos_reg < IDX_LIMIT)
        begin
            pos_next = pos_reg + 16'd1;
        end

        // Leading blanks and an optional sign.
        if (!done && phase_next == PH_LEAD)
        begin
            if (item.ch == CH_SPACE || item.ch == CH_TAB)
            begin
                done = 1'b1;
            end
            else if (item.ch == CH_MINUS)
            begin
                neg_next   = 1'b1;
                phase_next = PH_PREFIX;
                done       = 1'b1;
            end
            else if (item.ch == CH_PLUS)
            begin
                phase_next = PH_PREFIX;
                done       = 1'b1;
            end
            else
            begin
                phase_next = PH_PREFIX;
            end
        end

        // A leading zero may open a hex prefix or pick octal.
        if (!done && phase_next == PH_PREFIX)
        begin
            if (item.ch == CH_ZERO && (base_next == BASE_DETECT || base_next == BASE_HEX))
            begin
                phase_next = PH_ZERO;
                done       = 1'b1;
            end
            else
            begin
                if (base_next == BASE_DETECT)
                begin
                    base_next = BASE_DEC;
                end
                phase_next = PH_DIGITS;
            end
        end

        if (!done && phase_next == PH_ZERO)
        begin
            if (item.ch == CH_LOW_X || item.ch == CH_UP_X)
            begin
                phase_next = PH_XSEEN;
                done       = 1'b1;
            end
            else
            begin
                if (base_next == BASE_DETECT)
                begin
                    base_next = BASE_OCT;
                end
                phase_next = PH_DIGITS;
            end
        end

        // After "0x" a hex digit must follow, else the parse ends at the x.
        if (!done && phase_next == PH_XSEEN)
        begin
            if (worth < 7'(BASE_HEX))
            begin
                base_next  = BASE_HEX;
                phase_next = PH_DIGITS;
            end
            else
            begin
                stop       = STOP_AT_X;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
        end

        // Digit gathering: one multiply-add by the base.
        if (!done && phase_next == PH_DIGITS)
        begin
            if (worth < {1'b0, base_next})
            begin
                acc_next = acc_next * 64'(base_next) + 64'(worth);
            end
            else
            begin
                stop       = STOP_AT_BYTE;
                phase_next = PH_IDLE;
            end
        end
    end

    // Index reported for a stop at the x: the byte before, unless saturated.
    assign x_index = (pos_next < IDX_LIMIT && pos_next != 16'd0) ?
                     pos_next - 16'd1 : pos_next;

    // Outputs: the result that the byte in hand produces.
    always_comb
    begin
        emit             = 1'b0;
        result.value     = 64'sd0;
        result.end_index = 16'd0;
        result.status    = STATUS_OK;
        case (stop)
            STOP_NONE:
            begin
                emit = 1'b0;
            end
            STOP_BAD_RADIX:
            begin
                emit          = 1'b1;
                result.status = STATUS_BAD_RADIX;
            end
            STOP_AT_X:
            begin
                emit             = 1'b1;
                result.end_index = x_index;
            end
            STOP_AT_BYTE:
            begin
                emit             = 1'b1;
                result.value     = $signed(neg_next ? 64'd0 - acc_next : acc_next);
                result.end_index = pos_next;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            acc_reg   <= 64'd0;
            pos_reg   <= 16'd0;
            base_reg  <= BASE_DEC;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            base_reg  <= base_next;
        end
    end
endmodule

// ----- hdl/aip_out_stage.sv -----
module aip_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  aip_pkg::result_t load_result,
    input  logic             out_ready,
    output logic             out_valid,
    output aip_pkg::result_t out_result,
    output logic             out_free
);
    import aip_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new result may enter when the register is empty or is being drained.
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
endmodule

// ----- hdl/ascii_integer_parser.sv -----
// Radix string-to-integer converter. Bytes of a string arrive one per transaction on
// the byte channel, the first one marked by first=1; one result transaction (value,
// end_index, status) leaves at the byte that ends the number, NUL or any other byte
// that is not a digit of the radix, or at a first byte when the radix is invalid. The
// radix register (2..36, or 0 to detect it from a 0x or 0 prefix) is sampled at each
// first byte and resets to 10. The block takes one byte per clock cycle while the
// result side keeps up; a byte waits in the input register, passes through the digit
// decode and the 64-bit multiply-add of the accumulator by the base, which is the path
// that sets the clock rate, and its result is registered in the output register.
// Values wrap modulo 2^64 and the index saturates at 65535.
`include "ascii_integer_parser_defines.svh"

module ascii_integer_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    aip_in_if.sink     bytes,
    aip_out_if.source  results
);
    import aip_pkg::*;

    logic [5:0] radix_reg;
    in_item_t   in_item;
    in_item_t   item;
    logic       item_valid;
    logic       take;
    logic       emit;
    logic       out_free;
    result_t    parse_result;
    result_t    out_result;

    // Radix register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= BASE_DEC;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    assign in_item.ch    = bytes.ch;
    assign in_item.first = bytes.first;

    aip_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bytes.valid),
        .in_item    (in_item),
        .in_ready   (bytes.ready),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    aip_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .radix      (radix_reg),
        .out_free   (out_free),
        .take       (take),
        .emit       (emit),
        .result     (parse_result)
    );

    aip_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take && emit),
        .load_result (parse_result),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .out_result  (out_result),
        .out_free    (out_free)
    );

    assign results.value     = out_result.value;
    assign results.end_index = out_result.end_index;
    assign results.status    = out_result.status;

    // A bad-radix result carries nothing but its status.
    `AIP_ASSERT_SAME(a_bad_radix_zero, clk, rst_n, results.valid && results.status == STATUS_BAD_RADIX, results.value == 64'sd0 && results.end_index == 16'd0)
    // No byte is consumed while a finished result is stalled.
    `AIP_ASSERT_SAME(a_no_take_when_full, clk, rst_n, results.valid && !results.ready, !take)
    // A result that is produced shows up on the port in the next cycle.
    `AIP_ASSERT_NEXT(a_emit_shows, clk, rst_n, take && emit, results.valid)
    // An empty input register always accepts.
    `AIP_ASSERT_SAME(a_empty_accepts, clk, rst_n, !item_valid, bytes.ready)
endmodule

// ----- bench/tb_ascii_integer_parser.sv -----
`timescale 1ns / 1ps

module tb_ascii_integer_parser;
    import aip_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned IDLE_PCT     = 12;
    localparam int unsigned NO_WORTH     = 99;
    localparam int unsigned RANDOM_BYTES = 1600;
    localparam int unsigned LONG_RUN     = 65600;
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_BANG      = 8'h21;
    localparam logic [7:0]  CH_LOW_Q     = 8'h71;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;

    aip_in_if  bytes_if ();
    aip_out_if results_if ();

    ascii_integer_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bytes     (bytes_if),
        .results   (results_if)
    );

    // Expected results, oldest first, and run bookkeeping.
    result_t     expected_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int          hold_cycles = 0;
    bit          no_idle     = 1'b0;

    // Predictor state: the parse in progress and the radix register.
    phase_t      parse_phase  = PH_IDLE;
    logic        parse_negative = 1'b0;
    logic [63:0] parse_accum  = '0;
    logic [15:0] parse_index  = '0;
    logic [5:0]  parse_base   = BASE_DEC;
    logic [5:0]  radix_reg    = BASE_DEC;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Worth of an alphanumeric byte, or NO_WORTH for any other byte.
    function automatic int unsigned char_worth(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return c - CH_ZERO;
        end
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            return c - CH_LOW_A + 10;
        end
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            return c - CH_UP_A + 10;
        end
        return NO_WORTH;
    endfunction

    // Advances the predicted parse by one accepted byte. Returns 1 when the
    // byte ends the number, with the expected result in r.
    function automatic bit parse_step(input logic [7:0] c, input logic f,
                                      output result_t r);
        int unsigned w;
        logic [15:0] stop_idx;
        r = '0;
        w = char_worth(c);
        if (f)
        begin
            parse_negative = 1'b0;
            parse_accum    = '0;
            parse_index    = '0;
            parse_base     = radix_reg;
            if (radix_reg == BASE_BAD || radix_reg > BASE_MAX)
            begin
                r.status    = STATUS_BAD_RADIX;
                parse_phase = PH_IDLE;
                return 1'b1;
            end
            parse_phase = PH_LEAD;
        end
        else
        begin
            if (parse_phase == PH_IDLE)
            begin
                return 1'b0;
            end
            if (parse_index < IDX_LIMIT)
            begin
                parse_index++;
            end
        end

        // Leading blanks and an optional sign.
        if (parse_phase == PH_LEAD)
        begin
            if (c == CH_SPACE || c == CH_TAB)
            begin
                return 1'b0;
            end
            parse_phase = PH_PREFIX;
            if (c == CH_MINUS)
            begin
                parse_negative = 1'b1;
                return 1'b0;
            end
            if (c == CH_PLUS)
            begin
                return 1'b0;
            end
        end

        // A leading zero may open a hex prefix or select octal.
        if (parse_phase == PH_PREFIX)
        begin
            if (c == CH_ZERO && (parse_base == BASE_DETECT || parse_base == BASE_HEX))
            begin
                parse_phase = PH_ZERO;
                return 1'b0;
            end
            if (parse_base == BASE_DETECT)
            begin
                parse_base = BASE_DEC;
            end
            parse_phase = PH_DIGITS;
        end
        if (parse_phase == PH_ZERO)
        begin
            if (c == CH_LOW_X || c == CH_UP_X)
            begin
                parse_phase = PH_XSEEN;
                return 1'b0;
            end
            if (parse_base == BASE_DETECT)
            begin
                parse_base = BASE_OCT;
            end
            parse_phase = PH_DIGITS;
        end

        // After an x the prefix only counts if a hex digit follows.
        if (parse_phase == PH_XSEEN)
        begin
            if (w < 16)
            begin
                parse_base  = BASE_HEX;
                parse_phase = PH_DIGITS;
            end
            else
            begin
                stop_idx = (parse_index < IDX_LIMIT && parse_index > 0) ?
                           parse_index - 16'd1 : parse_index;
                r.end_index = stop_idx;
                r.status    = STATUS_OK;
                parse_phase = PH_IDLE;
                return 1'b1;
            end
        end

        // Gather digits until one is out of range for the base.
        if (w < parse_base)
        begin
            parse_accum = parse_accum * parse_base + w;
            return 1'b0;
        end
        r.value     = parse_negative ? -parse_accum : parse_accum;
        r.end_index = parse_index;
        r.status    = STATUS_OK;
        parse_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // Offers one byte, waits for the transaction and predicts its result.
    task automatic send_byte(input logic [7:0] c, input logic f);
        result_t r;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            bytes_if.valid = 1'b0;
            @(negedge clk);
        end
        bytes_if.valid = 1'b1;
        bytes_if.ch    = c;
        bytes_if.first = f;
        @(posedge clk);
        while (!bytes_if.ready)
        begin
            @(posedge clk);
        end
        if (parse_step(c, f, r))
        begin
            expected_results.push_back(r);
        end
    endtask

    // Sends a string with first set on its opening byte, then a NUL if asked.
    task automatic send_text(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == 0);
        end
        if (terminate)
        begin
            send_byte(CH_NUL, 1'b0);
        end
    endtask

    // Lets every outstanding result drain and the pipeline go quiet.
    task automatic wait_idle();
        @(negedge clk);
        bytes_if.valid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the radix register while the block is idle.
    task automatic set_radix(input logic [5:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        radix_reg = v;
    endtask

    // Digit character of a given worth, letters in either case.
    function automatic logic [7:0] digit_char(input int unsigned w);
        if (w < 10)
        begin
            return CH_ZERO + 8'(w);
        end
        return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(w - 10);
    endfunction

    // Builds and sends one random string, mostly well formed. Returns the
    // number of bytes that belong to the string itself.
    task automatic send_random_string(output int sent);
        logic [7:0]  text[$];
        int unsigned digit_base;
        int unsigned n;
        int unsigned pick;
        int unsigned prefix;
        bit          valid_radix;
        bit          noise_first;
        valid_radix = !(radix_reg == BASE_BAD || radix_reg > BASE_MAX);
        noise_first = 1'b1;
        if ($urandom_range(0, 99) < 12)
        begin
            // Noise: arbitrary bytes, possibly with no string start.
            n = $urandom_range(1, 8);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
            noise_first = 1'($urandom_range(0, 1));
        end
        else
        begin
            // Leading blanks and sign.
            if ($urandom_range(0, 1))
            begin
                n = $urandom_range(1, 3);
                repeat (n) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end
            pick = $urandom_range(0, 3);
            if (pick == 0)
            begin
                text.push_back(CH_MINUS);
            end
            else if (pick == 1)
            begin
                text.push_back(CH_PLUS);
            end

            // Optional prefix, mostly where the radix gives it a meaning.
            prefix = 3;
            if (((radix_reg == BASE_DETECT || radix_reg == BASE_HEX) &&
                 $urandom_range(0, 99) < 60) || $urandom_range(0, 99) < 5)
            begin
                prefix = $urandom_range(0, 2);
            end
            if (prefix <= 2)
            begin
                text.push_back(CH_ZERO);
            end
            if (prefix == 0)
            begin
                text.push_back(CH_LOW_X);
            end
            else if (prefix == 1)
            begin
                text.push_back(CH_UP_X);
            end

            if (radix_reg == BASE_DETECT)
            begin
                digit_base = (prefix <= 1) ? 16 : (prefix == 2) ? 8 : 10;
            end
            else if (valid_radix)
            begin
                digit_base = radix_reg;
            end
            else
            begin
                digit_base = 10;
            end

            // Digits; a few runs are long enough to wrap the value.
            n = ($urandom_range(0, 99) < 8) ? $urandom_range(13, 30) : $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                if (i == 0 && radix_reg == BASE_DETECT && prefix == 3)
                begin
                    text.push_back(digit_char($urandom_range(1, 9)));
                end
                else
                begin
                    text.push_back(digit_char($urandom_range(0, digit_base - 1)));
                end
            end

            // Terminator, or none so that the next string restarts the parse.
            pick = $urandom_range(0, 9);
            if (pick <= 4)
            begin
                text.push_back(CH_NUL);
            end
            else if (pick <= 6)
            begin
                text.push_back(CH_SPACE);
            end
            else if (pick == 7)
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick == 8)
            begin
                text.push_back(digit_base < 36 ?
                               digit_char($urandom_range(digit_base, 35)) : CH_BANG);
            end
        end

        for (int i = 0; i < text.size(); i++)
        begin
            send_byte(text[i], i == 0 && noise_first);
        end
        sent = text.size();

        // Stray bytes after the string, which the block ignores once the string has ended.
        if ($urandom_range(0, 99) < 10)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Reset radix, and bytes seen before any string has started.
    task automatic test_reset_defaults();
        send_byte(CH_ZERO + 8'd5, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text("  -42", 1'b1);
    endtask

    // Decimal: signs, no digits, wrap-around, restart and ignored bytes.
    task automatic test_decimal();
        set_radix(BASE_DEC);
        send_text("\t+7x", 1'b0);
        send_byte(CH_ZERO + 8'd9, 1'b0);
        send_text("-", 1'b1);
        send_text("18446744073709551617", 1'b1);
        send_text("-9223372036854775808", 1'b1);
        send_text("12", 1'b0);
        send_text("3", 1'b1);
    endtask

    // Base detection from the prefix, including a bare 0x.
    task automatic test_detect();
        set_radix(BASE_DETECT);
        send_text("0x1F", 1'b1);
        send_text("0X7g", 1'b0);
        send_text("017", 1'b1);
        send_text("09", 1'b0);
        send_text("0x", 1'b1);
        send_text("-0xq", 1'b0);
        send_text("123", 1'b1);
    endtask

    // Hex with and without a prefix, and the smallest and largest bases.
    task automatic test_fixed_bases();
        set_radix(BASE_HEX);
        send_text("0xff", 1'b1);
        send_text("0xZ", 1'b0);
        send_text("FFFFFFFFFFFFFFFFF", 1'b1);
        set_radix(6'd2);
        send_text("1012", 1'b0);
        set_radix(BASE_MAX);
        send_text("zZ9!", 1'b0);
    endtask

    // Invalid radix values give an immediate error result.
    task automatic test_invalid_radix();
        set_radix(BASE_BAD);
        send_text("12", 1'b1);
        set_radix(6'd37);
        send_text("5", 1'b0);
        set_radix(6'd63);
        send_text("7", 1'b1);
    endtask

    // Strings longer than the index counter, ending at a byte and at an x.
    task automatic test_index_limit();
        no_idle = 1'b1;
        set_radix(BASE_DEC);
        send_byte(CH_ZERO + 8'd1, 1'b1);
        for (int i = 0; i < LONG_RUN; i++)
        begin
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
        send_byte(CH_NUL, 1'b0);
        set_radix(BASE_HEX);
        send_byte(CH_SPACE, 1'b1);
        for (int i = 0; i < LONG_RUN; i++)
        begin
            send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
        end
        // The prefix continues the same string, so the index stays saturated.
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_LOW_X, 1'b0);
        send_byte(CH_LOW_Q, 1'b0);
        no_idle = 1'b0;
    endtask

    // Result side held off while short strings keep arriving.
    task automatic test_backpressure();
        set_radix(BASE_DEC);
        hold_cycles = 300;
        repeat (40)
        begin
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
            send_byte(CH_NUL, 1'b0);
        end
    endtask

    // Random strings over a sequence of radix settings.
    task automatic test_random_strings();
        logic [5:0] plan[16];
        int         phase_bytes;
        int         sent;
        plan = '{BASE_DEC, BASE_DETECT, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT, BASE_DETECT,
                 BASE_BAD, 6'd37, 6'd63, BASE_HEX, 6'd0, 6'd0, 6'd0, BASE_DETECT, BASE_DEC};
        for (int p = 0; p < 16; p++)
        begin
            if (p >= 11 && p <= 13)
            begin
                plan[p] = 6'($urandom_range(2, 36));
            end
            set_radix(plan[p]);
            no_idle = (p == 4);
            phase_bytes = 0;
            while (phase_bytes < RANDOM_BYTES / 16)
            begin
                send_random_string(sent);
                phase_bytes += sent;
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, a counted hold-off, or always ready.
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                results_if.ready = 1'b0;
                hold_cycles--;
            end
            else if (no_idle)
            begin
                results_if.ready = 1'b1;
            end
            else
            begin
                results_if.ready = ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: value %0d end_index %0d status %0d",
                       $signed(results_if.value), results_if.end_index, results_if.status);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (results_if.value !== want.value)
                begin
                    $error("value mismatch: expected %0d, actual %0d",
                           $signed(want.value), $signed(results_if.value));
                    error_count++;
                end
                if (results_if.end_index !== want.end_index)
                begin
                    $error("end_index mismatch: expected %0d, actual %0d",
                           want.end_index, results_if.end_index);
                    error_count++;
                end
                if (results_if.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, results_if.status);
                    error_count++;
                end
            end
        end
    end

    // Run time guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        bytes_if.valid = 1'b0;
        bytes_if.ch    = '0;
        bytes_if.first = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_decimal();
        test_detect();
        test_fixed_bases();
        test_invalid_radix();
        test_index_limit();
        test_backpressure();
        test_random_strings();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- ascii_integer_parser.f -----
+incdir+hdl
hdl/aip_pkg.sv
hdl/aip_channels.sv
hdl/aip_in_stage.sv
hdl/aip_parse.sv
hdl/aip_out_stage.sv
hdl/ascii_integer_parser.sv
bench/tb_ascii_integer_parser.sv
